// ----- hw/rtl/mcspg_pkg.sv -----
// Shared types, constants and helpers of the multi-channel servo pulse generator.
// Used by mcspg_frame_timer, mcspg_channel_bank and the top level; no dependencies.
`timescale 1ns / 1ps

package mcspg_pkg;

    // Field widths
    localparam int US_WIDTH      = 15;
    localparam int TICK_WIDTH    = 16;
    localparam int CHAN_WIDTH    = 3;
    localparam int LINE_COUNT    = 8;
    localparam int MASK_WIDTH    = 8;
    // Enough bits for a ticks-per-microsecond factor of up to 16
    localparam int TPU_WIDTH     = 5;
    localparam int PROD_WIDTH    = US_WIDTH + TPU_WIDTH;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [TICK_WIDTH-1:0] MAX_TICKS = 16'hffff;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_PERIOD = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ENABLE_MASK  = 1'd1;

    localparam logic [US_WIDTH-1:0]   FRAME_PERIOD_RESET = 15'd20000;
    localparam logic [MASK_WIDTH-1:0] ENABLE_MASK_RESET  = 8'd0;

    // Request codes carried on tuser
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_WIDTH = 1'b1;

    // Work for one request, decoded at the input register
    typedef struct packed {
        logic                  tick_en;
        logic                  wr_en;
        logic [CHAN_WIDTH-1:0] channel;
        logic [US_WIDTH-1:0]   width_us;
    } cmd_t;

    // Frame counter view after the current tick
    typedef struct packed {
        logic [TICK_WIDTH-1:0] count;
        logic                  frame_start;
        logic [US_WIDTH-1:0]   length_us;
    } frame_t;

    // Scale microseconds to ticks, saturate at the counter range
    function automatic logic [TICK_WIDTH-1:0] us_to_ticks(
        input logic [US_WIDTH-1:0]  us,
        input logic [TPU_WIDTH-1:0] tpu
    );
        logic [PROD_WIDTH-1:0] prod;
        prod = PROD_WIDTH'(us) * PROD_WIDTH'(tpu);
        if (prod > PROD_WIDTH'(MAX_TICKS)) begin
            return MAX_TICKS;
        end
        return prod[TICK_WIDTH-1:0];
    endfunction

endpackage

// ----- hw/rtl/mcspg_frame_timer.sv -----
// Frame counter: counts ticks, wraps at the scaled frame period, flags frame start.
// Depends on mcspg_pkg.
`timescale 1ns / 1ps

module mcspg_frame_timer #(
    parameter int TICKS_PER_US = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  logic [mcspg_pkg::US_WIDTH-1:0] frame_period_us,
    output mcspg_pkg::frame_t             frame
);
    import mcspg_pkg::*;

    // Frame length reported when the period is zero or saturated
    localparam logic [US_WIDTH-1:0] ZERO_LEN = US_WIDTH'(1 / TICKS_PER_US);
    localparam logic [US_WIDTH-1:0] SAT_LEN  = US_WIDTH'(int'(MAX_TICKS) / TICKS_PER_US);

    logic [TICK_WIDTH-1:0] tick_count_reg;
    logic [TICK_WIDTH-1:0] tick_count_next;
    logic [TICK_WIDTH-1:0] period_raw;
    logic [TICK_WIDTH-1:0] period_ticks;
    logic [TICK_WIDTH-1:0] count_inc;
    logic                  wrap;
    logic [US_WIDTH-1:0]   length_us;

    // Period in ticks, never below one tick
    always_comb begin
        period_raw   = us_to_ticks(frame_period_us, TPU_WIDTH'(TICKS_PER_US));
        period_ticks = (period_raw == '0) ? TICK_WIDTH'(1) : period_raw;
        if (period_raw == '0) begin
            length_us = ZERO_LEN;
        end else if (period_raw == MAX_TICKS) begin
            length_us = SAT_LEN;
        end else begin
            length_us = frame_period_us;
        end
    end

    // Advance and wrap the counter
    always_comb begin
        count_inc       = tick_count_reg + TICK_WIDTH'(1);
        wrap            = (count_inc >= period_ticks);
        tick_count_next = wrap ? '0 : count_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else if (tick_en) begin
            tick_count_reg <= tick_count_next;
        end
    end

    assign frame.count       = tick_count_next;
    assign frame.frame_start = wrap;
    assign frame.length_us   = wrap ? length_us : '0;

endmodule

// ----- hw/rtl/mcspg_channel_bank.sv -----
// Per-channel pulse width store and parallel width comparators.
// Depends on mcspg_pkg.
`timescale 1ns / 1ps

module mcspg_channel_bank #(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcspg_pkg::cmd_t                 cmd,
    input  logic                            fire,
    input  mcspg_pkg::frame_t               frame,
    input  logic [mcspg_pkg::MASK_WIDTH-1:0] enable_mask,
    output logic [mcspg_pkg::LINE_COUNT-1:0] lines
);
    import mcspg_pkg::*;

    // Only the first eight channels can be addressed
    localparam int NCH = (NUM_CHANNELS < LINE_COUNT) ? NUM_CHANNELS : LINE_COUNT;

    logic [TICK_WIDTH-1:0] width_ticks;
    logic [LINE_COUNT-1:0] lines_new;
    logic [LINE_COUNT-1:0] line_levels_reg;

    assign width_ticks = us_to_ticks(cmd.width_us, TPU_WIDTH'(TICKS_PER_US));

    for (genvar c = 0; c < LINE_COUNT; c++) begin : g_chan
        if (c < NCH) begin : g_used
            logic [TICK_WIDTH-1:0] width_reg;

            // Store a new width for this channel
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    width_reg <= MAX_TICKS;
                end else if (fire && cmd.wr_en && cmd.channel == CHAN_WIDTH'(c)) begin
                    width_reg <= width_ticks;
                end
            end

            // Hold the line high while the channel is enabled and the counter is below the width
            assign lines_new[c] = enable_mask[c] && (frame.count < width_reg);
        end else begin : g_unused
            assign lines_new[c] = 1'b0;
        end
    end

    // Lines change only on ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_levels_reg <= '0;
        end else if (fire && cmd.tick_en) begin
            line_levels_reg <= lines_new;
        end
    end

    assign lines = cmd.tick_en ? lines_new : line_levels_reg;

endmodule

// ----- hw/rtl/multi_channel_servo_pulse_generator.sv -----
// Top level of the multi-channel servo pulse generator: stream ports, config registers,
// input and result registers. Depends on mcspg_pkg, mcspg_frame_timer, mcspg_channel_bank.
`timescale 1ns / 1ps

// Usage
//   Requests arrive on the s_ stream: s_tuser = 0 is one timer tick, s_tuser = 1 sets
//   the pulse width of channel s_tdata[2:0] to s_tdata[17:3] microseconds.
//   Every request gives exactly one result on the m_ stream: the level of each servo
//   line, a frame start flag on m_tuser and, on a frame start, the frame length in us.
//   Throughput: one request per cycle while m_tready stays high; the counter update, the
//   eight width compares and the result all sit between the input register and the
//   result register.
//   The config port (cfg_we, cfg_addr, cfg_wdata) writes the frame period (index 0)
//   or the channel enable mask (index 1); write it only while no request is pending.
//   Reset: period 20000 us, all channels disabled, counter at zero, every stored width
//   at the maximum so an enabled line stays high until a width is written.
//   Stall: while m_tready is low the result holds; one more request is taken into
//   the input register, after which s_tready drops until the result is taken.
module multi_channel_servo_pulse_generator #(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [23:0]                          s_tdata,  // channel[2:0], width_us[17:3]
    input  logic                                 s_tuser,  // opcode
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,  // pulse_lines[7:0], frame_length_us[22:8]
    output logic                                 m_tuser,  // frame_start
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [mcspg_pkg::CFG_IDX_WIDTH-1:0]  cfg_addr,
    input  logic [mcspg_pkg::US_WIDTH-1:0]       cfg_wdata
);
    import mcspg_pkg::*;

    logic [US_WIDTH-1:0]   frame_period_us_reg;
    logic [MASK_WIDTH-1:0] enable_mask_reg;

    logic                  in_valid_reg;
    logic                  in_opcode_reg;
    logic [CHAN_WIDTH-1:0] in_channel_reg;
    logic [US_WIDTH-1:0]   in_width_reg;

    logic                  out_valid_reg;
    logic [LINE_COUNT-1:0] out_lines_reg;
    logic                  out_start_reg;
    logic [US_WIDTH-1:0]   out_length_reg;

    logic                  advance;
    logic                  fire;
    cmd_t                  cmd;
    frame_t                frame;
    logic [LINE_COUNT-1:0] lines;

    // Config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_period_us_reg <= FRAME_PERIOD_RESET;
            enable_mask_reg     <= ENABLE_MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_PERIOD: frame_period_us_reg <= cfg_wdata;
                REG_ENABLE_MASK:  enable_mask_reg     <= cfg_wdata[MASK_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees up when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_opcode_reg  <= s_tuser;
            in_channel_reg <= s_tdata[CHAN_WIDTH-1:0];
            in_width_reg   <= s_tdata[CHAN_WIDTH +: US_WIDTH];
        end
    end

    // Decode the held request
    always_comb begin
        cmd.tick_en  = (in_opcode_reg == OP_TICK);
        cmd.wr_en    = (in_opcode_reg == OP_SET_WIDTH);
        cmd.channel  = in_channel_reg;
        cmd.width_us = in_width_reg;
    end

    mcspg_frame_timer #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_frame_timer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_en         (fire && cmd.tick_en),
        .frame_period_us (frame_period_us_reg),
        .frame           (frame)
    );

    mcspg_channel_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TICKS_PER_US (TICKS_PER_US)
    ) u_channel_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .fire        (fire),
        .frame       (frame),
        .enable_mask (enable_mask_reg),
        .lines       (lines)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_lines_reg  <= lines;
            out_start_reg  <= cmd.tick_en && frame.frame_start;
            out_length_reg <= cmd.tick_en ? frame.length_us : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_start_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_lines_reg};

    // The input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    // A frame length is reported only with a frame start
    a_length_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[22:8] == '0))
        else $error("frame length outside a frame start");

    // A disabled channel never drives its line at a frame start
    a_mask_respected: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[7:0] & ~enable_mask_reg) == '0))
        else $error("disabled channel line driven");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of multi_channel_servo_pulse_generator: directed and random
// tick and set-width requests, a line-level predictor and result checks. Needs mcspg_pkg.

// One expected result: line levels, frame start flag, reported frame length
typedef struct packed {
    logic [7:0]  lines;
    logic        start;
    logic [14:0] length_us;
} servo_result_t;

// Tracks the frame counter and stored widths, predicts the result of each request
class servo_line_predictor;
    localparam int NUM_CH = 8;
    localparam int TPU    = 2;

    logic [14:0]   period_us;
    logic [7:0]    enable_mask;
    logic [15:0]   tick_count;
    logic [15:0]   width_ticks [NUM_CH];
    logic [7:0]    line_levels;
    servo_result_t expected_q [$];
    int            error_count;

    function new();
        period_us   = mcspg_pkg::FRAME_PERIOD_RESET;
        enable_mask = mcspg_pkg::ENABLE_MASK_RESET;
        tick_count  = '0;
        line_levels = '0;
        error_count = 0;
        foreach (width_ticks[c]) width_ticks[c] = 16'hffff;
    endfunction

    // Microseconds to ticks, saturated to the counter range
    function logic [15:0] scale_us(input logic [14:0] us);
        int unsigned t;
        t = int'(us) * TPU;
        return (t > 32'hffff) ? 16'hffff : t[15:0];
    endfunction

    function void write_register(input logic idx, input logic [14:0] value);
        if (idx == mcspg_pkg::REG_FRAME_PERIOD) begin
            period_us = value;
        end else if (idx == mcspg_pkg::REG_ENABLE_MASK) begin
            enable_mask = value[7:0];
        end
    endfunction

    // Advance the state for one accepted request and queue its result
    function void predict_request(input logic op, input logic [2:0] chan,
                                  input logic [14:0] width_us);
        servo_result_t res;
        int unsigned   period;
        logic [7:0]    lines;
        res = '0;
        if (op == mcspg_pkg::OP_SET_WIDTH) begin
            if (int'(chan) < NUM_CH) width_ticks[chan] = scale_us(width_us);
        end else begin
            period = scale_us(period_us);
            if (period == 0) period = 1;
            tick_count = tick_count + 16'd1;
            if (int'(tick_count) >= period) begin
                tick_count    = '0;
                res.start     = 1'b1;
                res.length_us = 15'(period / TPU);
            end
            lines = '0;
            for (int c = 0; c < NUM_CH && c < 8; c++) begin
                if (enable_mask[c] && tick_count < width_ticks[c]) lines[c] = 1'b1;
            end
            line_levels = lines;
        end
        res.lines = line_levels;
        expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(input logic [7:0] lines, input logic start,
                               input logic [14:0] length_us);
        servo_result_t exp_res;
        if (expected_q.size() == 0) begin
            $error("unexpected result: pulse_lines %h frame_start %b frame_length_us %0d",
                   lines, start, length_us);
            error_count++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (lines !== exp_res.lines) begin
            $error("pulse_lines: expected %h, actual %h", exp_res.lines, lines);
            error_count++;
        end
        if (start !== exp_res.start) begin
            $error("frame_start: expected %b, actual %b", exp_res.start, start);
            error_count++;
        end
        if (length_us !== exp_res.length_us) begin
            $error("frame_length_us: expected %0d, actual %0d", exp_res.length_us, length_us);
            error_count++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    localparam int NUM_CHANNELS = 8;
    localparam int TICKS_PER_US = 2;
    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_LIMIT   = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // channel[2:0], width_us[17:3]
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // pulse_lines[7:0], frame_length_us[22:8]
    logic        m_tuser;   // frame_start
    logic        cfg_we;
    logic [mcspg_pkg::CFG_IDX_WIDTH-1:0] cfg_addr;
    logic [mcspg_pkg::US_WIDTH-1:0]      cfg_wdata;

    servo_line_predictor line_pred;
    bit          tx_idle_on;
    bit          rx_idle_on;
    logic [14:0] cur_period_us;
    int          idle_cycles;

    multi_channel_servo_pulse_generator #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .TICKS_PER_US(TICKS_PER_US)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one request after a random gap, hold it until taken
    task automatic send_request(input logic op, input logic [2:0] chan,
                                input logic [14:0] width_us);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, width_us, chan};
        do @(posedge aclk); while (!s_tready);
        line_pred.predict_request(op, chan, width_us);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_request(mcspg_pkg::OP_TICK, 3'($urandom_range(0, 7)),
                     15'($urandom_range(0, 32767)));
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (line_pred.pending() > 0);
    endtask

    // Write both registers back to back; only called while the block is idle
    task automatic write_config(input logic [14:0] period_us, input logic [7:0] mask);
        cfg_we    <= 1'b1;
        cfg_addr  <= mcspg_pkg::REG_FRAME_PERIOD;
        cfg_wdata <= period_us;
        @(negedge aclk);
        cfg_addr  <= mcspg_pkg::REG_ENABLE_MASK;
        cfg_wdata <= {7'd0, mask};
        @(negedge aclk);
        cfg_we <= 1'b0;
        line_pred.write_register(mcspg_pkg::REG_FRAME_PERIOD, period_us);
        line_pred.write_register(mcspg_pkg::REG_ENABLE_MASK, {7'd0, mask});
        cur_period_us = period_us;
        @(negedge aclk);
    endtask

    // Result side: random stall, then take one result and check it
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            line_pred.check_result(m_tdata[7:0], m_tuser, m_tdata[22:8]);
            @(negedge aclk);
        end
    end

    // Stop the run when neither side has moved a request or result for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int          n_random;
        int          phase_len;
        logic [14:0] period;
        logic [7:0]  mask;
        logic [14:0] width;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = mcspg_pkg::OP_TICK;
        cfg_we        = 1'b0;
        cfg_addr      = mcspg_pkg::REG_FRAME_PERIOD;
        cfg_wdata     = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        cur_period_us = mcspg_pkg::FRAME_PERIOD_RESET;
        line_pred     = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: all lines disabled
        send_tick();
        send_tick();
        send_request(mcspg_pkg::OP_SET_WIDTH, 3'd0, 15'd0);
        send_tick();
        wait_for_results();

        // Shortest period, all channels on, the largest width on channel 7 and a 1 us width on channel 1
        write_config(15'd1, 8'hff);
        repeat (3) send_tick();
        send_request(mcspg_pkg::OP_SET_WIDTH, 3'd7, 15'd32767);
        send_request(mcspg_pkg::OP_SET_WIDTH, 3'd1, 15'd1);
        send_request(mcspg_pkg::OP_SET_WIDTH, 3'd2, 15'h5555);
        send_request(mcspg_pkg::OP_SET_WIDTH, 3'd5, 15'h2aaa);
        repeat (4) send_tick();
        wait_for_results();

        // Longest period, then lower it while the counter is past the new end
        write_config(15'd32767, 8'h81);
        repeat (6) send_tick();
        wait_for_results();
        write_config(15'd2, 8'h81);
        repeat (3) send_tick();
        wait_for_results();

        // Random phases, each with its own settings and idle pattern
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       period = 15'd1;
                1:       period = 15'd32767;
                2:       period = 15'($urandom_range(1, 32767));
                default: period = 15'($urandom_range(1, 30));
            endcase
            case ($urandom_range(0, 5))
                0:       mask = 8'h00;
                1:       mask = 8'hff;
                default: mask = 8'($urandom_range(0, 255));
            endcase
            write_config(period, mask);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(20, 80);
            // Keep the last phase within the request budget
            if (phase_len > RANDOM_ITEMS - n_random) phase_len = RANDOM_ITEMS - n_random;
            repeat (phase_len) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_tick();
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        width = 15'($urandom_range(0, 32767));
                    end else begin
                        width = 15'($urandom_range(0, (int'(cur_period_us) + 2 > 32767) ?
                                                   32767 : int'(cur_period_us) + 2));
                    end
                    send_request(mcspg_pkg::OP_SET_WIDTH, 3'($urandom_range(0, 7)), width);
                end
                // Now and then hold off until the result queue is empty
                if ($urandom_range(0, 49) == 0) wait_for_results();
                n_random++;
            end
            wait_for_results();
        end

        // Drain, then give any stray result a chance to show up
        wait_for_results();
        repeat (8) @(negedge aclk);
        if (line_pred.error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
